// ----- design/slot_pool_allocator_defines.svh -----
// Assertion macros for the slot pool allocator.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot pool allocator: assertion failed");
// Next-cycle implication.
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot pool allocator: assertion failed");
`else
`define SPA_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/spa_pkg.sv -----
// Shared types and constants of the slot pool allocator.
// No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

   localparam int SLOTS_DEFAULT     = 1024;
   localparam int REF_WIDTH_DEFAULT = 16;

   // fixed field widths of the transaction ports
   localparam int OP_W         = 2;
   localparam int SLOT_FIELD_W = 10;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 10;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC        = 2'd0,
      OP_ALLOC_PARENT = 2'd1,
      OP_FREE         = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_IGNORED   = 2'd2
   } status_type;

endpackage

// ----- design/spa_rec_store.sv -----
// Per-slot record memory {used mark, reference count} with its clearing pass.
// Depends on spa_pkg (defaults only).
`timescale 1ns / 1ps

module spa_rec_store #(
   parameter int SLOTS     = spa_pkg::SLOTS_DEFAULT,
   parameter int REF_WIDTH = spa_pkg::REF_WIDTH_DEFAULT,
   localparam int SLOT_W   = $clog2(SLOTS),
   localparam int REC_W    = REF_WIDTH + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mem_en,
   input  logic              mem_we,
   input  logic [SLOT_W-1:0] mem_addr,
   input  logic [REC_W-1:0]  mem_wdata,
   output logic [REC_W-1:0]  mem_rdata,
   output logic              ready
);

   localparam logic [SLOT_W-1:0] LAST_ADDR = SLOT_W'(SLOTS - 1);

   logic [REC_W-1:0]  rec_mem [SLOTS];
   logic [REC_W-1:0]  rdata_ff;
   logic              clearing_ff, clearing_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [REC_W-1:0]  wr_data;

   // clearing pass owns the port until every entry is zero
   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         if (clr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
      wr_en   = clearing_ff | (mem_en & mem_we);
      wr_addr = clearing_ff ? clr_ff : mem_addr;
      wr_data = clearing_ff ? '0 : mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      if (mem_en && !mem_we && !clearing_ff) begin
         rdata_ff <= rec_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;
   assign ready     = !clearing_ff;

endmodule

// ----- design/slot_pool_allocator.sv -----
// Top level of the slot pool allocator: control sequencer and free-list link memory.
// Depends on spa_pkg, spa_rec_store and slot_pool_allocator_defines.svh.
`timescale 1ns / 1ps
`include "slot_pool_allocator_defines.svh"

// Slot pool allocator.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; req_operation selects alloc, alloc with parent, or free, and req_slot
// names the parent or the slot to release.
// Result channel: one result per transaction, held on rsp_* for one cycle with
// rsp_strobe high. The receiver cannot stall, so nothing waits on it.
// Timing: the accept edge issues the memory reads (free-list link at the head,
// record at the parent or at the freed slot); the next cycle decides and writes
// back; the result shows in the cycle after that. Alloc with parent also passes
// through ST_PARENT: the parent's count needs a second write on the single
// record port. After alloc and free, busy drops while the result is shown, so
// the edge that ends the strobe cycle can take a new transaction; after alloc
// with parent busy drops in the cycle after the strobe, once ST_PARENT is done.
// Same-entry overlap cannot occur: each transaction finishes its writes before
// the next read is issued.
// Reset: synchronous. After it a clearing pass zeroes the record memory (used
// marks and reference counts), one entry a cycle, with busy high until it ends.
// Links need no clearing: a link is written before its slot joins the free list.
// Parent indexes are not stored: nothing in the block ever reads them back.

module slot_pool_allocator #(
   parameter int SLOTS     = spa_pkg::SLOTS_DEFAULT,
   parameter int REF_WIDTH = spa_pkg::REF_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [spa_pkg::OP_W-1:0]         req_operation,
   input  logic [spa_pkg::SLOT_FIELD_W-1:0] req_slot,
   output logic                             rsp_strobe,
   output logic [spa_pkg::SLOT_FIELD_W-1:0] rsp_granted_slot,
   output logic [spa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [spa_pkg::COUNT_W-1:0]      rsp_active_count
);

   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int SF_W     = spa_pkg::SLOT_FIELD_W;
   localparam int CNT_W    = spa_pkg::COUNT_W;
   localparam int CMP_W    = (SLOT_W > SF_W) ? SLOT_W : SF_W;
   localparam int REC_W    = REF_WIDTH + 1;
   localparam int USED_BIT = REF_WIDTH;
   localparam logic [SLOT_W-1:0] LAST_BUMP = SLOT_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_PARENT = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   spa_pkg::op_type            op_ff;
   logic [SF_W-1:0]            slot_ff;
   logic [SLOT_W-1:0]          parent_ff;
   logic [SLOT_W-1:0]          bump_ff, bump_in;
   logic [SLOT_W-1:0]          head_ff, head_in;
   logic [SLOT_W-1:0]          active_ff, active_in;
   logic [SLOT_W-1:0]          link_rd_ff;
   logic [REC_W-1:0]           par_data_ff, par_data_in;
   logic [SLOT_W-1:0]          grant_ff, grant_in;
   spa_pkg::status_type        status_ff, status_in;
   logic                       strobe_ff, strobe_in;

   logic [SLOT_W-1:0]          link_mem [SLOTS];
   logic                       link_we;

   logic                       st_en, st_we, st_ready;
   logic [SLOT_W-1:0]          st_addr;
   logic [REC_W-1:0]           st_wdata, st_rdata;

   logic                       accept;
   logic [SF_W-1:0]            parent_rem;
   logic [SLOT_W-1:0]          parent_idx;
   logic [REF_WIDTH-1:0]       ref_old, ref_inc;

   assign busy   = (state_ff != ST_IDLE) || !st_ready;
   assign accept = start && !busy;

   // parent index modulo SLOTS: restoring subtract of SLOTS shifted, 8 steps
   // cover every SLOTS down to 4 against a 10-bit index
   always_comb begin
      parent_rem = req_slot;
      for (int k = 7; k >= 0; k--) begin
         if (int'(parent_rem) >= (SLOTS << k)) begin
            parent_rem = parent_rem - SF_W'(SLOTS << k);
         end
      end
      parent_idx = SLOT_W'(parent_rem);
   end

   // saturating bump of the parent's count
   assign ref_old = st_rdata[REF_WIDTH-1:0];
   assign ref_inc = (&ref_old) ? ref_old : ref_old + 1'b1;

   always_comb begin
      state_in    = state_ff;
      bump_in     = bump_ff;
      head_in     = head_ff;
      active_in   = active_ff;
      par_data_in = par_data_ff;
      grant_in    = '0;
      status_in   = spa_pkg::STATUS_DONE;
      strobe_in   = 1'b0;
      st_en       = 1'b0;
      st_we       = 1'b0;
      st_addr     = parent_idx;
      st_wdata    = '0;
      link_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               st_en    = 1'b1;
               st_addr  = (req_operation == spa_pkg::OP_FREE) ? SLOT_W'(req_slot)
                                                              : parent_idx;
            end
         end
         ST_EXEC: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
            case (op_ff)
               spa_pkg::OP_ALLOC, spa_pkg::OP_ALLOC_PARENT: begin
                  if (head_ff != '0) begin
                     grant_in = head_ff;
                     head_in  = link_rd_ff;
                  end else if (bump_ff >= LAST_BUMP) begin
                     status_in = spa_pkg::STATUS_EXHAUSTED;
                  end else begin
                     grant_in = bump_ff;
                     bump_in  = bump_ff + 1'b1;
                  end
                  if (status_in == spa_pkg::STATUS_DONE) begin
                     active_in = active_ff + 1'b1;
                     st_en     = 1'b1;
                     st_we     = 1'b1;
                     st_addr   = grant_in;
                     st_wdata  = {1'b1, {REF_WIDTH{1'b0}}};
                     if (op_ff == spa_pkg::OP_ALLOC_PARENT) begin
                        state_in = ST_PARENT;
                        // parent is the new slot: cleared, then raised to one
                        if (parent_ff == grant_in) begin
                           par_data_in = {1'b1, REF_WIDTH'(1)};
                        end else begin
                           par_data_in = {st_rdata[USED_BIT], ref_inc};
                        end
                     end
                  end
               end
               spa_pkg::OP_FREE: begin
                  if (slot_ff == '0 || CMP_W'(slot_ff) >= CMP_W'(bump_ff) ||
                      !st_rdata[USED_BIT]) begin
                     status_in = spa_pkg::STATUS_IGNORED;
                  end else begin
                     st_en     = 1'b1;
                     st_we     = 1'b1;
                     st_addr   = SLOT_W'(slot_ff);
                     st_wdata  = {1'b0, ref_old};
                     link_we   = 1'b1;
                     head_in   = SLOT_W'(slot_ff);
                     active_in = active_ff - 1'b1;
                  end
               end
               default: begin
                  status_in = spa_pkg::STATUS_IGNORED;
               end
            endcase
         end
         ST_PARENT: begin
            st_en    = 1'b1;
            st_we    = 1'b1;
            st_addr  = parent_ff;
            st_wdata = par_data_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bump_ff   <= SLOT_W'(1);
         head_ff   <= '0;
         active_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bump_ff   <= bump_in;
         head_ff   <= head_in;
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= spa_pkg::op_type'(req_operation);
         slot_ff   <= req_slot;
         parent_ff <= parent_idx;
      end
      if (state_ff == ST_EXEC) begin
         grant_ff    <= grant_in;
         status_ff   <= status_in;
         par_data_ff <= par_data_in;
      end
   end

   // free-list links: read at the head on accept, written on a valid free
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[SLOT_W'(slot_ff)] <= head_ff;
      end
      if (accept) begin
         link_rd_ff <= link_mem[head_ff];
      end
   end

   spa_rec_store #(
      .SLOTS     (SLOTS),
      .REF_WIDTH (REF_WIDTH)
   ) u_rec_store (
      .clock     (clock),
      .reset     (reset),
      .mem_en    (st_en),
      .mem_we    (st_we),
      .mem_addr  (st_addr),
      .mem_wdata (st_wdata),
      .mem_rdata (st_rdata),
      .ready     (st_ready)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_granted_slot = SF_W'(grant_ff);
   assign rsp_status       = status_ff;
   assign rsp_active_count = CNT_W'(active_ff);

   `SPA_ASSERT_NEXT(a_accept_holds_busy, clock, reset, start && !busy, busy)
   `SPA_ASSERT_NEXT(a_exec_gives_result, clock, reset, state_ff == ST_EXEC, rsp_strobe)
   `SPA_ASSERT_NOW(a_exhausted_no_grant, clock, reset,
      rsp_strobe && rsp_status == spa_pkg::STATUS_EXHAUSTED, rsp_granted_slot == '0)
   `SPA_ASSERT_NOW(a_head_below_bump, clock, reset, head_ff != '0, head_ff < bump_ff)
   `SPA_ASSERT_NOW(a_active_below_bump, clock, reset, 1'b1, active_ff < bump_ff)

endmodule
